[design/dlzbd_pkg.sv]
`default_nettype none

package dlzbd_pkg;

  localparam int unsigned CODE_W     = 18;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned DICT_DEPTH = 256;
  localparam int unsigned MAX_PREFIX = 16;
  localparam int unsigned LEN_BIAS   = 3;
  localparam int unsigned ESC_VALUE  = 256;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BIT   = 2'd1,
    REQ_START = 2'd2,
    REQ_END   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_BYTE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_END       = 3'd2,
    ST_BAD_CODE  = 3'd3,
    ST_BAD_DIST  = 3'd4,
    ST_COPY_LONG = 3'd5,
    ST_CODE_LONG = 3'd6
  } status_e;

endpackage

`default_nettype wire

[design/dlzbd_ram.sv]
`default_nettype none

module dlzbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/dictionary_lz_bitstream_decoder_unit.sv]
// Bit-serial decoder for a dictionary-plus-LZ compressed stream.
// The input channel carries one word per request: a dictionary load, one
// code bit, the start of a new stream or the end of input. The output
// channel carries one word per decoded byte or event, with the status, the
// running byte count and a last flag on the final word caused by a request.
// The output limit is written through cfg_we_i/cfg_wdata_i; the user must
// see that it is written only while idle, as the block does not enforce it.
// A literal goes from the dictionary via S_LIT to the output register.
// A copy sets its read pointer in S_CSET, then per byte reads history in
// S_CRD and writes back in S_CWR, which also fills the output register, as
// each byte may be the source of the next. Event words go through S_PUT.
// Dictionary and history live in single-port-write synchronous RAMs with
// registered reads. Neither is cleared; reset only clears the decoder
// state, the byte count and the write pointer, and sets the limit to 65535.
// When the receiver stalls, the word waits in the output register and the
// decoder holds until it is taken; new requests are accepted only when
// the previous request has produced all its words.
module dictionary_lz_bitstream_decoder_unit #(
  parameter int unsigned HISTORY_DEPTH = 16384,
  parameter int unsigned MAX_COPY      = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  dict_index_i,
  input  wire logic [7:0]  dict_byte_i,
  input  wire logic        code_bit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       status_o,
  output logic             last_o,
  output logic [15:0]      written_count_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned LW = $clog2(MAX_COPY + 1);
  localparam int unsigned CW = dlzbd_pkg::CODE_W;
  localparam int unsigned NW = dlzbd_pkg::CNT_W;
  localparam int unsigned BW = dlzbd_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_LIT,
    S_CSET,
    S_CRD,
    S_CWR
  } state_e;

  state_e state_q, state_d;

  logic [15:0]   out_limit_q, out_limit_d;
  logic [BW-1:0] bw_q, bw_d;
  logic          in_prefix_q, in_prefix_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pfx_q, pfx_d;
  logic [CW-1:0] sfx_q, sfx_d;
  logic          copy_pending_q, copy_pending_d;
  logic [PW-1:0] dist_q, dist_d;
  logic          halted_q, halted_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [LW-1:0] copy_left_q, copy_left_d;
  dlzbd_pkg::status_e pend_status_q, pend_status_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  dlzbd_pkg::status_e out_status_q, out_status_d;
  logic          out_last_q, out_last_d;
  logic [BW-1:0] out_count_q, out_count_d;

  logic          slot_free;
  logic          in_fire;
  logic [CW-1:0] sfx_next;
  logic [NW-1:0] cnt_dec;
  logic [CW-1:0] value_w;
  logic [CW-1:0] dist_w;
  logic [BW-1:0] bw_inc;
  logic          full;
  logic [7:0]    emit_byte;
  logic [AW-1:0] wptr_inc;
  logic [AW-1:0] rptr_inc;

  logic          dict_we;
  logic          dict_re;
  logic [7:0]    dict_rdata;
  logic          hist_we;
  logic          hist_re;
  logic [7:0]    hist_rdata;

  dlzbd_ram #(
    .WIDTH (8),
    .DEPTH (dlzbd_pkg::DICT_DEPTH)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_index_i),
    .wdata_i (dict_byte_i),
    .re_i    (dict_re),
    .raddr_i (value_w[7:0]),
    .rdata_o (dict_rdata)
  );

  dlzbd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (wptr_q),
    .wdata_i (emit_byte),
    .re_i    (hist_re),
    .raddr_i (rptr_q),
    .rdata_o (hist_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;

  assign sfx_next = {sfx_q[CW-2:0], code_bit_i};
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - NW'(1) : cnt_q;
  assign value_w  = pfx_q + sfx_next;
  assign dist_w   = value_w - CW'(dlzbd_pkg::ESC_VALUE);

  assign bw_inc    = bw_q + BW'(1);
  assign full      = (bw_inc >= out_limit_q);
  assign emit_byte = (state_q == S_LIT) ? dict_rdata : hist_rdata;
  assign wptr_inc  = (wptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
  assign rptr_inc  = (rptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : rptr_q + AW'(1);

  always_comb begin
    state_d        = state_q;
    out_limit_d    = out_limit_q;
    bw_d           = bw_q;
    in_prefix_d    = in_prefix_q;
    cnt_d          = cnt_q;
    pfx_d          = pfx_q;
    sfx_d          = sfx_q;
    copy_pending_d = copy_pending_q;
    dist_d         = dist_q;
    halted_d       = halted_q;
    wptr_d         = wptr_q;
    rptr_d         = rptr_q;
    copy_left_d    = copy_left_q;
    pend_status_d  = pend_status_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_byte_d     = out_byte_q;
    out_status_d   = out_status_q;
    out_last_d     = out_last_q;
    out_count_d    = out_count_q;
    dict_we        = 1'b0;
    dict_re        = 1'b0;
    hist_we        = 1'b0;
    hist_re        = 1'b0;

    if (cfg_we_i) begin
      out_limit_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (dlzbd_pkg::req_e'(req_type_i))
            dlzbd_pkg::REQ_LOAD: begin
              dict_we = 1'b1;
            end
            dlzbd_pkg::REQ_START: begin
              bw_d           = '0;
              wptr_d         = '0;
              in_prefix_d    = 1'b1;
              cnt_d          = '0;
              pfx_d          = '0;
              sfx_d          = '0;
              copy_pending_d = 1'b0;
              dist_d         = '0;
              halted_d       = 1'b0;
            end
            dlzbd_pkg::REQ_END: begin
              halted_d      = 1'b1;
              pend_status_d = dlzbd_pkg::ST_END;
              state_d       = S_PUT;
            end
            dlzbd_pkg::REQ_BIT: begin
              if (!halted_q) begin
                if (in_prefix_q) begin
                  if (code_bit_i && (cnt_q >= NW'(dlzbd_pkg::MAX_PREFIX))) begin
                    halted_d      = 1'b1;
                    pend_status_d = dlzbd_pkg::ST_CODE_LONG;
                    state_d       = S_PUT;
                  end else begin
                    cnt_d = cnt_q + NW'(1);
                    pfx_d = {pfx_q[CW-2:0], code_bit_i};
                    if (!code_bit_i) begin
                      sfx_d       = '0;
                      in_prefix_d = 1'b0;
                    end
                  end
                end else begin
                  sfx_d = sfx_next;
                  cnt_d = cnt_dec;
                  if (cnt_dec == '0) begin
                    in_prefix_d = 1'b1;
                    pfx_d       = '0;
                    sfx_d       = '0;
                    if (copy_pending_q) begin
                      copy_pending_d = 1'b0;
                      if (value_w > CW'(MAX_COPY - dlzbd_pkg::LEN_BIAS)) begin
                        halted_d      = 1'b1;
                        pend_status_d = dlzbd_pkg::ST_COPY_LONG;
                        state_d       = S_PUT;
                      end else begin
                        copy_left_d = LW'(value_w + CW'(dlzbd_pkg::LEN_BIAS));
                        state_d     = S_CSET;
                      end
                    end else if (value_w == CW'(dlzbd_pkg::ESC_VALUE)) begin
                      halted_d      = 1'b1;
                      pend_status_d = dlzbd_pkg::ST_BAD_CODE;
                      state_d       = S_PUT;
                    end else if (value_w < CW'(dlzbd_pkg::ESC_VALUE)) begin
                      dict_re = 1'b1;
                      state_d = S_LIT;
                    end else if ((dist_w > CW'(bw_q)) || (dist_w > CW'(HISTORY_DEPTH))) begin
                      halted_d      = 1'b1;
                      pend_status_d = dlzbd_pkg::ST_BAD_DIST;
                      state_d       = S_PUT;
                    end else begin
                      dist_d         = PW'(dist_w);
                      copy_pending_d = 1'b1;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PUT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = '0;
          out_status_d = pend_status_q;
          out_last_d   = 1'b1;
          out_count_d  = bw_q;
          state_d      = S_IDLE;
        end
      end
      S_CSET: begin
        if (PW'(wptr_q) >= dist_q) begin
          rptr_d = AW'(PW'(wptr_q) - dist_q);
        end else begin
          rptr_d = AW'(PW'(wptr_q) + PW'(HISTORY_DEPTH) - dist_q);
        end
        state_d = S_CRD;
      end
      S_CRD: begin
        hist_re = 1'b1;
        state_d = S_CWR;
      end
      S_LIT, S_CWR: begin
        if (slot_free) begin
          hist_we      = 1'b1;
          wptr_d       = wptr_inc;
          bw_d         = bw_inc;
          out_valid_d  = 1'b1;
          out_byte_d   = emit_byte;
          out_status_d = full ? dlzbd_pkg::ST_FULL : dlzbd_pkg::ST_BYTE;
          out_count_d  = bw_inc;
          if (full) begin
            halted_d = 1'b1;
          end
          if (state_q == S_LIT) begin
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            copy_left_d = copy_left_q - LW'(1);
            rptr_d      = rptr_inc;
            out_last_d  = full || (copy_left_q == LW'(1));
            state_d     = (full || (copy_left_q == LW'(1))) ? S_IDLE : S_CRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_limit_q    <= 16'hFFFF;
      bw_q           <= '0;
      in_prefix_q    <= 1'b1;
      cnt_q          <= '0;
      pfx_q          <= '0;
      sfx_q          <= '0;
      copy_pending_q <= 1'b0;
      dist_q         <= '0;
      halted_q       <= 1'b0;
      wptr_q         <= '0;
      rptr_q         <= '0;
      copy_left_q    <= '0;
      pend_status_q  <= dlzbd_pkg::ST_BYTE;
      out_valid_q    <= 1'b0;
      out_byte_q     <= '0;
      out_status_q   <= dlzbd_pkg::ST_BYTE;
      out_last_q     <= 1'b0;
      out_count_q    <= '0;
    end else begin
      state_q        <= state_d;
      out_limit_q    <= out_limit_d;
      bw_q           <= bw_d;
      in_prefix_q    <= in_prefix_d;
      cnt_q          <= cnt_d;
      pfx_q          <= pfx_d;
      sfx_q          <= sfx_d;
      copy_pending_q <= copy_pending_d;
      dist_q         <= dist_d;
      halted_q       <= halted_d;
      wptr_q         <= wptr_d;
      rptr_q         <= rptr_d;
      copy_left_q    <= copy_left_d;
      pend_status_q  <= pend_status_d;
      out_valid_q    <= out_valid_d;
      out_byte_q     <= out_byte_d;
      out_status_q   <= out_status_d;
      out_last_q     <= out_last_d;
      out_count_q    <= out_count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;
  assign written_count_o = out_count_q;

  a_copy_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD) |-> (copy_left_q != '0) && (copy_left_q <= LW'(MAX_COPY)))
    else $error("copy length out of range during copy");

  a_suffix_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_prefix_q |-> (cnt_q != '0))
    else $error("suffix phase entered with no bits left");

  a_full_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LIT || state_q == S_CWR) && slot_free && full) |=>
      (halted_q && state_q == S_IDLE))
    else $error("limit reached without halting");

  a_wptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q <= AW'(HISTORY_DEPTH - 1)) && (rptr_q <= AW'(HISTORY_DEPTH - 1)))
    else $error("history pointer beyond depth");

endmodule

`default_nettype wire

[verif/dictionary_lz_bitstream_decoder_unit_tb.sv]
module dictionary_lz_bitstream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HISTORY_DEPTH = 16384;
  localparam int unsigned MAX_COPY      = 64;
  localparam int unsigned TOTAL_WORDS   = 350;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_200_000;
  localparam int unsigned MAX_CODE      = 32'h3FFFD;

  typedef enum int { ACT_WORD, ACT_CFG, ACT_DRAIN } act_e;

  typedef struct {
    act_e              act;
    dlzbd_pkg::req_e   req;
    logic [7:0]        index;
    logic [7:0]        value;
    logic              code_bit;
    logic [15:0]       cfg;
    int unsigned       gap;
  } item_t;

  typedef struct {
    logic [7:0]         out_byte;
    dlzbd_pkg::status_e status;
    logic               last;
    logic [15:0]        count;
  } result_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type  = dlzbd_pkg::REQ_LOAD;
  logic [7:0]  dict_index = '0;
  logic [7:0]  dict_byte  = '0;
  logic        code_bit   = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b1;
  logic [7:0]  out_byte;
  logic [2:0]  out_status;
  logic        out_last;
  logic [15:0] written_count;

  dictionary_lz_bitstream_decoder_unit #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .MAX_COPY     (MAX_COPY)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .dict_index_i   (dict_index),
    .dict_byte_i    (dict_byte),
    .code_bit_i     (code_bit),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .status_o       (out_status),
    .last_o         (out_last),
    .written_count_o(written_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  item_t       pend_q[$];
  result_t     decoded_q[$];
  item_t       cur;
  int unsigned gap_cnt    = 0;
  int unsigned settle_cnt = 0;
  int unsigned stall_cnt  = 0;
  bit          rx_calm    = 1'b0;
  int unsigned n_fail     = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_events   = 0;
  int unsigned n_cfg      = 0;

  logic [7:0]  m_dict [dlzbd_pkg::DICT_DEPTH];
  logic [7:0]  m_hist [HISTORY_DEPTH];
  logic [15:0] m_limit     = 16'hFFFF;
  logic [15:0] m_count     = '0;
  bit          m_in_prefix = 1'b1;
  logic [4:0]  m_nbits     = '0;
  logic [17:0] m_prefix    = '0;
  logic [17:0] m_suffix    = '0;
  bit          m_copy      = 1'b0;
  logic [15:0] m_dist      = '0;
  bit          m_halted    = 1'b0;

  task automatic push_decoded(input logic [7:0] data, input dlzbd_pkg::status_e st);
    result_t r;
    r.out_byte = data;
    r.status   = st;
    r.last     = 1'b0;
    r.count    = m_count;
    decoded_q  = {decoded_q, r};
  endtask

  task automatic clear_code();
    m_in_prefix = 1'b1;
    m_nbits     = '0;
    m_prefix    = '0;
    m_suffix    = '0;
  endtask

  task automatic emit_byte(input logic [7:0] data, output bit full);
    m_hist[m_count % HISTORY_DEPTH] = data;
    m_count = m_count + 16'd1;
    full = (m_count >= m_limit);
    if (full) begin
      m_halted = 1'b1;
      push_decoded(data, dlzbd_pkg::ST_FULL);
    end else begin
      push_decoded(data, dlzbd_pkg::ST_BYTE);
    end
  endtask

  task automatic apply_value(input logic [17:0] value);
    int unsigned len;
    int unsigned back_dist;
    logic [15:0] src;
    bit          full;
    full = 1'b0;
    if (m_copy) begin
      m_copy = 1'b0;
      len = value + dlzbd_pkg::LEN_BIAS;
      if (len > MAX_COPY) begin
        m_halted = 1'b1;
        push_decoded('0, dlzbd_pkg::ST_COPY_LONG);
      end else begin
        for (int k = 0; k < len && !full; k++) begin
          src = m_count - m_dist;
          emit_byte(m_hist[src % HISTORY_DEPTH], full);
        end
      end
    end else if (value == dlzbd_pkg::ESC_VALUE) begin
      m_halted = 1'b1;
      push_decoded('0, dlzbd_pkg::ST_BAD_CODE);
    end else if (value < dlzbd_pkg::ESC_VALUE) begin
      emit_byte(m_dict[value[7:0]], full);
    end else begin
      back_dist = value - dlzbd_pkg::ESC_VALUE;
      if (back_dist > m_count || back_dist > HISTORY_DEPTH) begin
        m_halted = 1'b1;
        push_decoded('0, dlzbd_pkg::ST_BAD_DIST);
      end else begin
        m_dist = back_dist[15:0];
        m_copy = 1'b1;
      end
    end
  endtask

  task automatic apply_bit(input logic b);
    logic [17:0] value;
    if (m_in_prefix) begin
      if (b) begin
        if (m_nbits >= dlzbd_pkg::MAX_PREFIX) begin
          m_halted = 1'b1;
          push_decoded('0, dlzbd_pkg::ST_CODE_LONG);
        end else begin
          m_nbits  = m_nbits + 5'd1;
          m_prefix = {m_prefix[16:0], 1'b1};
        end
      end else begin
        m_nbits     = m_nbits + 5'd1;
        m_prefix    = {m_prefix[16:0], 1'b0};
        m_suffix    = '0;
        m_in_prefix = 1'b0;
      end
    end else begin
      m_suffix = {m_suffix[16:0], b};
      if (m_nbits != 0) m_nbits = m_nbits - 5'd1;
      if (m_nbits == 0) begin
        value = m_prefix + m_suffix;
        clear_code();
        apply_value(value);
      end
    end
  endtask

  task automatic predict_word(input item_t it);
    int unsigned n_before;
    result_t     r;
    n_before = decoded_q.size();
    case (it.req)
      dlzbd_pkg::REQ_LOAD: begin
        m_dict[it.index] = it.value;
      end
      dlzbd_pkg::REQ_START: begin
        m_count  = '0;
        clear_code();
        m_copy   = 1'b0;
        m_dist   = '0;
        m_halted = 1'b0;
      end
      dlzbd_pkg::REQ_END: begin
        m_halted = 1'b1;
        push_decoded('0, dlzbd_pkg::ST_END);
      end
      default: begin
        if (!m_halted) apply_bit(it.code_bit);
      end
    endcase
    if (decoded_q.size() > n_before) begin
      r = decoded_q[decoded_q.size() - 1];
      r.last = 1'b1;
      decoded_q[decoded_q.size() - 1] = r;
    end
  endtask

  always @(posedge clk) begin : drive
    logic next_valid;
    logic next_we;
    if (rst_n) begin
      next_valid = in_valid;
      next_we    = 1'b0;
      if (in_valid && in_ready) begin
        predict_word(cur);
        next_valid = 1'b0;
        n_sent++;
      end
      if (!next_valid && pend_q.size() != 0) begin
        if (pend_q[0].act == ACT_WORD) begin
          if (gap_cnt < pend_q[0].gap) begin
            gap_cnt++;
          end else begin
            cur = pend_q.pop_front();
            gap_cnt = 0;
            req_type   <= cur.req;
            dict_index <= cur.index;
            dict_byte  <= cur.value;
            code_bit   <= cur.code_bit;
            next_valid = 1'b1;
          end
        end else if (decoded_q.size() != 0) begin
          settle_cnt = 0;
        end else if (settle_cnt < SETTLE_CYCLES) begin
          settle_cnt++;
        end else begin
          if (pend_q[0].act == ACT_CFG) begin
            next_we = 1'b1;
            cfg_wdata <= pend_q[0].cfg;
            m_limit = pend_q[0].cfg;
            n_cfg++;
          end
          settle_cnt = 0;
          pend_q.delete(0);
        end
      end
      in_valid <= next_valid;
      cfg_we   <= next_we;
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    logic    next_ready;
    if (rst_n) begin
      next_ready = out_ready;
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output word: out_byte %0h status %0d", out_byte, out_status);
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
            n_fail++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            n_fail++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            n_fail++;
          end
          if (written_count !== want.count) begin
            $error("written_count: expected %0d, got %0d", want.count, written_count);
            n_fail++;
          end
          if (want.status != dlzbd_pkg::ST_BYTE && want.status != dlzbd_pkg::ST_FULL) begin
            n_events++;
          end
          n_checked++;
        end
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        stall_cnt  = rx_calm ? 0 : $urandom_range(0, 3);
        next_ready = (stall_cnt == 0);
      end else if (!out_ready) begin
        if (stall_cnt > 0) stall_cnt--;
        next_ready = (stall_cnt == 0);
      end
      out_ready <= next_ready;
    end
  end

  int unsigned gen_count  = 0;
  int unsigned gen_limit  = 16'hFFFF;
  int unsigned gen_items  = 0;
  bit          gen_halted = 1'b0;
  bit          gen_calm   = 1'b0;
  bit          gen_loaded [dlzbd_pkg::DICT_DEPTH];

  task automatic add_word(input dlzbd_pkg::req_e req, input logic [7:0] index,
                          input logic [7:0] value, input logic bit_v);
    item_t it;
    it.act      = ACT_WORD;
    it.req      = req;
    it.index    = index;
    it.value    = value;
    it.code_bit = bit_v;
    it.cfg      = '0;
    it.gap      = gen_calm ? 0 : $urandom_range(0, 3);
    pend_q      = {pend_q, it};
    if (req == dlzbd_pkg::REQ_LOAD) gen_loaded[index] = 1'b1;
    gen_items++;
  endtask

  task automatic add_control(input act_e act, input logic [15:0] cfg);
    item_t it;
    it.act      = act;
    it.req      = dlzbd_pkg::REQ_LOAD;
    it.index    = '0;
    it.value    = '0;
    it.code_bit = 1'b0;
    it.cfg      = cfg;
    it.gap      = 0;
    pend_q      = {pend_q, it};
  endtask

  task automatic add_load(input logic [7:0] index);
    add_word(dlzbd_pkg::REQ_LOAD, index, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_bit(input logic b);
    add_word(dlzbd_pkg::REQ_BIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), b);
  endtask

  task automatic add_start();
    add_word(dlzbd_pkg::REQ_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    gen_count  = 0;
    gen_halted = 1'b0;
  endtask

  task automatic add_end();
    add_word(dlzbd_pkg::REQ_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    gen_halted = 1'b1;
  endtask

  task automatic add_limit(input logic [15:0] limit);
    add_control(ACT_CFG, limit);
    gen_limit = limit;
    add_start();
  endtask

  task automatic add_code(input int unsigned v);
    int          n;
    int unsigned suffix;
    n = 0;
    while (v >= (32'd1 << (n + 2)) - 2) n++;
    suffix = v - ((32'd1 << (n + 1)) - 2);
    repeat (n) add_bit(1'b1);
    add_bit(1'b0);
    for (int i = n; i >= 0; i--) add_bit(suffix[i]);
  endtask

  task automatic add_literal(input int unsigned v);
    add_code(v);
    gen_count++;
    if (gen_count >= gen_limit) gen_halted = 1'b1;
  endtask

  task automatic add_any_literal();
    int unsigned v;
    v = $urandom_range(0, 255);
    while (!gen_loaded[v]) v = $urandom_range(0, 255);
    add_literal(v);
  endtask

  task automatic add_copy(input int unsigned back_dist, input int unsigned len);
    add_code(dlzbd_pkg::ESC_VALUE + back_dist);
    add_code(len - dlzbd_pkg::LEN_BIAS);
    gen_count += len;
    if (gen_count >= gen_limit) gen_halted = 1'b1;
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned copy_dist;
    int unsigned len;

    for (int i = 0; i < dlzbd_pkg::DICT_DEPTH; i++) gen_loaded[i] = 1'b0;

    add_limit(16'hFFFF);
    for (int i = 0; i < 16; i++) add_load(8'(i));
    for (int i = 248; i < 256; i++) add_load(8'(i));
    add_load(8'd128);

    add_literal(0);
    add_literal(255);
    add_literal(128);
    add_copy(1, dlzbd_pkg::LEN_BIAS);
    add_copy(3, MAX_COPY);
    add_word(dlzbd_pkg::REQ_LOAD, 8'd5, 8'hA5, 1'b0);
    add_literal(5);
    add_bit(1'b1);
    add_bit(1'b1);
    add_end();
    add_bit(1'b0);
    add_bit(1'b1);
    add_end();
    add_start();
    add_literal(7);
    add_code(dlzbd_pkg::ESC_VALUE);
    add_start();
    add_literal(9);
    add_code(dlzbd_pkg::ESC_VALUE + 2);
    add_start();
    add_code(MAX_CODE);
    add_start();
    add_literal(1);
    add_code(dlzbd_pkg::ESC_VALUE + 1);
    add_code(MAX_COPY - dlzbd_pkg::LEN_BIAS + 1);
    add_start();
    repeat (dlzbd_pkg::MAX_PREFIX + 1) add_bit(1'b1);
    add_control(ACT_DRAIN, '0);
    add_limit(16'd0);
    add_literal(3);
    add_literal(4);
    add_limit(16'd10);
    add_literal(2);
    add_copy(1, 20);
    add_limit(16'hFFFF);

    while (gen_items < TOTAL_WORDS) begin
      if ($urandom_range(0, 7) == 0) gen_calm = !gen_calm;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (gen_halted || $urandom_range(0, 9) == 0) add_start();
        repeat ($urandom_range(1, 6)) begin
          if (gen_count != 0 && $urandom_range(0, 1) == 1) begin
            copy_dist = $urandom_range(1, (gen_count < HISTORY_DEPTH) ? gen_count
                                                                      : HISTORY_DEPTH);
            len = ($urandom_range(0, 5) == 0) ? MAX_COPY
                                              : $urandom_range(dlzbd_pkg::LEN_BIAS, 12);
            add_copy(copy_dist, len);
          end else if ($urandom_range(0, 7) == 0) begin
            add_literal($urandom_range(0, 1) ? 255 : 0);
          end else begin
            add_any_literal();
          end
        end
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 24)) add_bit(1'($urandom_range(0, 1)));
        gen_halted = 1'b1;
      end else if (pick < 86) begin
        case ($urandom_range(0, 5))
          0: add_code(dlzbd_pkg::ESC_VALUE);
          1: add_code(dlzbd_pkg::ESC_VALUE + gen_count + $urandom_range(1, 1000));
          2: begin
            add_any_literal();
            add_code(dlzbd_pkg::ESC_VALUE + 1);
            add_code($urandom_range(MAX_COPY - dlzbd_pkg::LEN_BIAS + 1, 2000));
          end
          3: repeat (dlzbd_pkg::MAX_PREFIX + 1 + $urandom_range(0, 3)) add_bit(1'b1);
          4: begin
            repeat ($urandom_range(1, 5)) add_bit(1'($urandom_range(0, 1)));
            add_end();
          end
          default: add_end();
        endcase
        gen_halted = 1'b1;
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 3)) add_load(8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        case ($urandom_range(0, 4))
          0: add_limit(16'($urandom_range(0, 1)));
          1: add_limit(16'($urandom_range(2, 40)));
          2: add_limit(16'($urandom_range(41, 3000)));
          default: add_limit(16'hFFFF);
        endcase
      end else begin
        add_control(ACT_DRAIN, '0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d expected output words never arrived", decoded_q.size());
      n_fail++;
    end

    $display("Drove %0d input words and %0d output limit writes.", n_sent, n_cfg);
    $display("Compared %0d output words, %0d of them end or error events.", n_checked, n_events);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
